[hw/rtl/kam_pkg.sv]
package kam_pkg;

  localparam int LETTER_W    = 5;
  localparam int DEF_LETTERS = 26;

  // op codes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_MOVE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // move classes
  localparam logic [1:0] CLS_RESIZE = 2'd0;
  localparam logic [1:0] CLS_TSWAP  = 2'd1;
  localparam logic [1:0] CLS_KSWAP  = 2'd2;

  // config register indexes
  localparam logic [1:0] CFG_GROW_THR = 2'd0;
  localparam logic [1:0] CFG_SWAP_THR = 2'd1;
  localparam logic [1:0] CFG_MIN_KW   = 2'd2;
  localparam logic [1:0] CFG_MAX_KW   = 2'd3;

  // reset values
  localparam logic [15:0]         GROW_THR_RESET = 16'd2621;
  localparam logic [15:0]         SWAP_THR_RESET = 16'd34079;
  localparam logic [LETTER_W-1:0] MIN_KW_RESET   = 5'd3;
  localparam logic [LETTER_W-1:0] MAX_KW_RESET   = 5'd13;
  localparam logic [LETTER_W-1:0] KW_RESET       = 5'd3;

  typedef struct packed {
    logic [1:0]          op;
    logic [15:0]         random_fraction;
    logic                coin_up;
    logic [LETTER_W-1:0] first_pos;
    logic [LETTER_W-1:0] second_pos;
    logic [LETTER_W-1:0] letter_in;
    logic [LETTER_W-1:0] keyword_in;
  } in_item_t;

  typedef struct packed {
    logic                status;
    logic [1:0]          move_class;
    logic [LETTER_W-1:0] keyword_len;
    logic [LETTER_W-1:0] position;
    logic [LETTER_W-1:0] letter;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [15:0]         grow_threshold;
    logic [15:0]         swap_threshold;
    logic [LETTER_W-1:0] min_keyword;
    logic [LETTER_W-1:0] max_keyword;
  } cfg_t;

  // one write port, one read port per cycle
  typedef struct packed {
    logic                we;
    logic [LETTER_W-1:0] waddr;
    logic [LETTER_W-1:0] wdata;
    logic                re;
    logic [LETTER_W-1:0] raddr;
  } mem_req_t;

endpackage

[hw/rtl/keyed_alphabet_move_engine.sv]
// Keyed alphabet move engine. Holds an alphabet of ALPHABET_LETTERS letters
// (a keyword prefix followed by the remaining letters in ascending order) in a
// single-port-read, single-port-write synchronous memory, plus the keyword
// length. Ops: load one entry and the keyword length, apply one annealing
// move (resize, keyword-tail swap, in-keyword swap, picked by random_fraction
// against the two thresholds), or stream the alphabet out as one beat per
// letter with last on the final beat. Out-of-range positions give status 1
// and leave everything unchanged; op 3 is dropped with no beat. Items are
// handled one at a time; the next item is taken as soon as the previous
// item's final beat sits in the output register. Resize and keyword-tail
// swap end in a tail rebuild that reads the keyword once, then walks the
// letters until the tail is full. A read issues, captures and emits each
// of the N letters in turn (N = ALPHABET_LETTERS, 26 by default). A beat
// held back by a low out_ready stalls the block until it is taken. Reset
// gives the identity alphabet at once (per-entry valid bits, no clearing
// pass), keyword length 3 and the default thresholds/limits. The user must
// write the config registers through cfg_write/cfg_index/cfg_data only
// while the block is idle; the block itself does not enforce this.
module keyed_alphabet_move_engine
  import kam_pkg::*;
#(
  parameter int ALPHABET_LETTERS = DEF_LETTERS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [5:0] N6      = 6'(ALPHABET_LETTERS);
  localparam logic [5:0] KW_MAX6 = 6'(ALPHABET_LETTERS - 1);

  cfg_t                cfg;
  mem_req_t            mem_req;
  logic [LETTER_W-1:0] mem_rdata;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grow_threshold <= GROW_THR_RESET;
      cfg.swap_threshold <= SWAP_THR_RESET;
      cfg.min_keyword    <= MIN_KW_RESET;
      cfg.max_keyword    <= MAX_KW_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GROW_THR: cfg.grow_threshold <= cfg_data;
        CFG_SWAP_THR: cfg.swap_threshold <= cfg_data;
        CFG_MIN_KW:   cfg.min_keyword    <= cfg_data[LETTER_W-1:0];
        CFG_MAX_KW:   cfg.max_keyword    <= cfg_data[LETTER_W-1:0];
        default:      cfg.grow_threshold <= cfg.grow_threshold;
      endcase
    end
  end

  // alphabet store
  kam_alpha_mem #(
    .ALPHABET_LETTERS(ALPHABET_LETTERS)
  ) u_mem (
    .clk  (clk),
    .rst  (rst),
    .req  (mem_req),
    .rdata(mem_rdata)
  );

  // op sequencer, swap/rebuild/readout, output register
  kam_ctrl #(
    .ALPHABET_LETTERS(ALPHABET_LETTERS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .mem_req  (mem_req),
    .mem_rdata(mem_rdata)
  );

  // no read and write of the same entry in one cycle (no forwarding path)
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("memory read and write hit the same entry");

  // writes stay inside the alphabet
  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> ({1'b0, mem_req.waddr} < N6))
    else $error("memory write out of range");

  // only readout produces non-final beats, and those are clean
  a_readout_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.last) |-> (!out_item.status && out_item.move_class == CLS_RESIZE))
    else $error("non-final beat not a readout beat");

  // keyword length always within 1..N-1
  a_kw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.keyword_len != '0 && {1'b0, out_item.keyword_len} <= KW_MAX6))
    else $error("keyword length out of range");

  // no new item is taken during a swap or rebuild-fill write
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (mem_req.we && mem_req.waddr != in_item.first_pos) |-> !(in_valid && in_ready) ||
    (mem_req.wdata == in_item.letter_in))
    else $error("item accepted during sequencer write");

endmodule

[hw/rtl/kam_alpha_mem.sv]
module kam_alpha_mem
  import kam_pkg::*;
#(
  parameter int ALPHABET_LETTERS = DEF_LETTERS
) (
  input  logic                clk,
  input  logic                rst,
  input  mem_req_t            req,
  output logic [LETTER_W-1:0] rdata
);

  localparam int AW = (ALPHABET_LETTERS > 1) ? $clog2(ALPHABET_LETTERS) : 1;

  logic [LETTER_W-1:0]         mem [ALPHABET_LETTERS];
  logic [ALPHABET_LETTERS-1:0] vld;
  logic [AW-1:0]               wa;
  logic [AW-1:0]               ra;

  assign wa = req.waddr[AW-1:0];
  assign ra = req.raddr[AW-1:0];

  // entry never written reads as its own index (identity alphabet)
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.we) begin
      vld[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[wa] <= req.wdata;
    end
    if (req.re) begin
      rdata <= vld[ra] ? mem[ra] : LETTER_W'(ra);
    end
  end

endmodule

[hw/rtl/kam_ctrl.sv]
module kam_ctrl
  import kam_pkg::*;
#(
  parameter int ALPHABET_LETTERS = DEF_LETTERS
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_item,
  output mem_req_t            mem_req,
  input  logic [LETTER_W-1:0] mem_rdata
);

  localparam int AW = (ALPHABET_LETTERS > 1) ? $clog2(ALPHABET_LETTERS) : 1;
  localparam int CW = $clog2(ALPHABET_LETTERS + 1);
  localparam logic [CW-1:0] N_C     = CW'(ALPHABET_LETTERS);
  localparam logic [CW-1:0] LAST_C  = CW'(ALPHABET_LETTERS - 1);
  localparam logic [5:0]    N6      = 6'(ALPHABET_LETTERS);
  localparam logic [5:0]    KW_MAX6 = 6'(ALPHABET_LETTERS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SW_B,
    S_SW_W1,
    S_SW_W2,
    S_RB_KW,
    S_RB_FILL,
    S_RD_ISSUE,
    S_RD_DATA,
    S_EMIT
  } state_t;

  state_t                      state;
  logic [LETTER_W-1:0]         kw;
  in_item_t                    item;
  logic [1:0]                  cls;
  logic [LETTER_W-1:0]         tmp_a;
  logic [CW-1:0]               cnt;
  logic [CW-1:0]               fill_m;
  logic [ALPHABET_LETTERS-1:0] seen;
  logic                        rd_pend;
  logic                        more;
  out_item_t                   pend;

  logic                accept;
  logic                slot_free;
  logic [5:0]          kw6;
  logic                load_ok;
  logic                is_resize;
  logic                is_tswap;
  logic                tswap_ok;
  logic                kswap_ok;
  logic [5:0]          rk;
  logic [LETTER_W-1:0] resize_kw;
  logic                fill_done;
  logic                rd_last;

  function automatic out_item_t mk_res(input logic st, input logic [1:0] c,
                                       input logic [LETTER_W-1:0] k);
    out_item_t r;
    r.status      = st;
    r.move_class  = c;
    r.keyword_len = k;
    r.position    = '0;
    r.letter      = '0;
    r.last        = 1'b1;
    return r;
  endfunction

  assign in_ready  = (state == S_IDLE) && !rst;
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign kw6       = {1'b0, kw};

  assign load_ok = ({1'b0, in_item.first_pos} < N6) && ({1'b0, in_item.letter_in} < N6) &&
                   (in_item.keyword_in != '0) && ({1'b0, in_item.keyword_in} <= KW_MAX6);
  assign is_resize = in_item.random_fraction < cfg.grow_threshold;
  assign is_tswap  = !is_resize && (in_item.random_fraction < cfg.swap_threshold);
  assign tswap_ok  = (in_item.first_pos < kw) && (in_item.second_pos >= kw) &&
                     ({1'b0, in_item.second_pos} < N6);
  assign kswap_ok  = (in_item.first_pos < kw) && (in_item.second_pos < kw);

  // resize: forced grow at min, forced shrink at max, else coin; then clamp
  always_comb begin
    priority if (kw <= cfg.min_keyword) begin
      rk = kw6 + 6'd1;
    end else if (kw >= cfg.max_keyword) begin
      rk = kw6 - 6'd1;
    end else if (in_item.coin_up) begin
      rk = kw6 + 6'd1;
    end else begin
      rk = kw6 - 6'd1;
    end
    priority if (rk == 6'd0) begin
      resize_kw = 5'd1;
    end else if (rk > KW_MAX6) begin
      resize_kw = KW_MAX6[LETTER_W-1:0];
    end else begin
      resize_kw = rk[LETTER_W-1:0];
    end
  end

  assign fill_done = (fill_m == N_C) || (cnt == N_C);
  assign rd_last   = (cnt == LAST_C);

  // memory port
  always_comb begin
    mem_req = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && in_item.op == OP_LOAD && load_ok) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = in_item.first_pos;
          mem_req.wdata = in_item.letter_in;
        end else if (accept && in_item.op == OP_MOVE && !is_resize &&
                     ((is_tswap && tswap_ok) || (!is_tswap && kswap_ok))) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = in_item.first_pos;
        end
      end
      S_SW_B: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = item.second_pos;
      end
      S_SW_W1: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = item.first_pos;
        mem_req.wdata = mem_rdata;
      end
      S_SW_W2: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = item.second_pos;
        mem_req.wdata = tmp_a;
      end
      S_RB_KW: begin
        mem_req.re    = 6'(cnt) < kw6;
        mem_req.raddr = LETTER_W'(cnt);
      end
      S_RB_FILL: begin
        if (!fill_done && !seen[cnt[AW-1:0]]) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = LETTER_W'(fill_m);
          mem_req.wdata = LETTER_W'(cnt);
        end
      end
      S_RD_ISSUE: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = LETTER_W'(cnt);
      end
      S_RD_DATA, S_EMIT: begin
        mem_req = '0;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kw        <= KW_RESET;
      rd_pend   <= 1'b0;
      more      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && slot_free) begin
        out_valid <= 1'b1;
        out_item  <= pend;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item <= in_item;
            more <= 1'b0;
            unique case (in_item.op)
              OP_LOAD: begin
                if (load_ok) begin
                  kw <= in_item.keyword_in;
                end
                pend  <= mk_res(!load_ok, CLS_RESIZE, load_ok ? in_item.keyword_in : kw);
                state <= S_EMIT;
              end
              OP_MOVE: begin
                if (is_resize) begin
                  kw      <= resize_kw;
                  cls     <= CLS_RESIZE;
                  seen    <= '0;
                  cnt     <= '0;
                  rd_pend <= 1'b0;
                  state   <= S_RB_KW;
                end else if (is_tswap) begin
                  cls <= CLS_TSWAP;
                  if (tswap_ok) begin
                    state <= S_SW_B;
                  end else begin
                    pend  <= mk_res(1'b1, CLS_TSWAP, kw);
                    state <= S_EMIT;
                  end
                end else begin
                  cls <= CLS_KSWAP;
                  if (kswap_ok) begin
                    state <= S_SW_B;
                  end else begin
                    pend  <= mk_res(1'b1, CLS_KSWAP, kw);
                    state <= S_EMIT;
                  end
                end
              end
              OP_READ: begin
                cnt   <= '0;
                state <= S_RD_ISSUE;
              end
              default: begin
                state <= S_IDLE;  // unused op: no beat
              end
            endcase
          end
        end
        S_SW_B: begin
          tmp_a <= mem_rdata;
          state <= S_SW_W1;
        end
        S_SW_W1: begin
          state <= S_SW_W2;
        end
        S_SW_W2: begin
          if (cls == CLS_TSWAP) begin
            seen    <= '0;
            cnt     <= '0;
            rd_pend <= 1'b0;
            state   <= S_RB_KW;
          end else begin
            pend  <= mk_res(1'b0, cls, kw);
            state <= S_EMIT;
          end
        end
        S_RB_KW: begin
          // mark letters present in the keyword, one read in flight
          if (rd_pend && ({1'b0, mem_rdata} < N6)) begin
            seen[mem_rdata[AW-1:0]] <= 1'b1;
          end
          rd_pend <= mem_req.re;
          if (mem_req.re) begin
            cnt <= cnt + CW'(1);
          end else if (!rd_pend) begin
            cnt    <= '0;
            fill_m <= CW'(kw);
            state  <= S_RB_FILL;
          end
        end
        S_RB_FILL: begin
          // walk letters in ascending order, append the unseen ones
          if (fill_done) begin
            pend  <= mk_res(1'b0, cls, kw);
            state <= S_EMIT;
          end else begin
            if (!seen[cnt[AW-1:0]]) begin
              fill_m <= fill_m + CW'(1);
            end
            cnt <= cnt + CW'(1);
          end
        end
        S_RD_ISSUE: begin
          state <= S_RD_DATA;
        end
        S_RD_DATA: begin
          pend.status      <= 1'b0;
          pend.move_class  <= CLS_RESIZE;
          pend.keyword_len <= kw;
          pend.position    <= LETTER_W'(cnt);
          pend.letter      <= mem_rdata;
          pend.last        <= rd_last;
          more             <= !rd_last;
          cnt              <= cnt + CW'(1);
          state            <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            state <= more ? S_RD_ISSUE : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
